>>> hw/rtl/sac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// Types and fixed constants shared by the cache tag store simulator blocks.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 32;
    localparam int IN_ADDR_W    = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;

    typedef enum logic [1:0] {
        MODE_INSTR  = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_STORE  = 2'd2,
        MODE_MODIFY = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_BITS   = 2'd0,
        REG_WAYS       = 2'd1,
        REG_BLOCK_BITS = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN
    } t_back_state;

    typedef struct packed {
        t_mode                mode;
        logic [IN_ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             eviction;
        logic [CNT_W-1:0] total_hits;
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_evictions;
        logic             last_result;
    } t_result;

endpackage
`default_nettype wire

>>> hw/rtl/sac_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_fifo
// Small register queue; head entry is presented combinationally.
// ----------------------------------------------------------------------------
module sac_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + (AW + 1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/sac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_front
// Holds the geometry registers, classifies accesses and splits them into
// lookup operations (set, tag, fill stamp, last flag) for the back end.
// ----------------------------------------------------------------------------
module sac_front
    import sac_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  wire t_access               i_access,
    output logic                       o_full,
    input  wire logic                  i_ready,
    input  wire logic                  i_opq_full,
    output logic                       o_op_push,
    output logic [STAMP_W+1+((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)+ADDR_WIDTH-1:0] o_op_data,
    output logic [$clog2(MAX_WAYS+1)-1:0] o_ways
);

    localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SBW  = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int EW   = $clog2(MAX_WAYS + 1);
    localparam int SHW  = $clog2(MAX_SET_BITS + (1 << BLOCK_BITS_W));
    localparam int OP_W = STAMP_W + 1 + SIW + ADDR_WIDTH;

    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [WAYS_W-1:0]       r_ways;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [STAMP_W-1:0]      r_access_cnt;
    logic                    r_pend;
    logic [OP_W-1:0]         r_pend_op;

    logic [SBW-1:0]          set_eff;
    logic [ADDR_WIDTH-1:0]   addr_w;
    logic [ADDR_WIDTH-1:0]   set_shift;
    logic [SHW-1:0]          tag_shift;
    logic [ADDR_WIDTH-1:0]   tag;
    logic [SIW-1:0]          set_idx;
    logic                    accept;
    logic                    is_lookup;
    logic                    is_modify;

    // Geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways       <= WAYS_W'(1);
            r_block_bits <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                REG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLOCK_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the geometry to what the storage holds
    assign set_eff = (32'(r_set_bits) > 32'(MAX_SET_BITS)) ? SBW'(MAX_SET_BITS)
                                                           : SBW'(r_set_bits);
    assign o_ways  = (r_ways == '0) ? EW'(1)
                   : (32'(r_ways) > 32'(MAX_WAYS)) ? EW'(MAX_WAYS) : EW'(r_ways);

    if (ADDR_WIDTH > IN_ADDR_W) begin : g_addr_ext
        assign addr_w = {{(ADDR_WIDTH - IN_ADDR_W){1'b0}}, i_access.address};
    end else begin : g_addr_trunc
        assign addr_w = i_access.address[ADDR_WIDTH-1:0];
    end

    assign tag_shift = SHW'(set_eff) + SHW'(r_block_bits);
    assign tag       = (32'(tag_shift) >= 32'(ADDR_WIDTH)) ? '0 : (addr_w >> tag_shift);
    assign set_shift = addr_w >> r_block_bits;

    always_comb begin
        for (int i = 0; i < SIW; i++) begin
            set_idx[i] = set_shift[i] & (i < int'(set_eff));
        end
    end

    always_comb begin
        is_lookup = 1'b0;
        is_modify = 1'b0;
        unique case (i_access.mode) inside
            MODE_INSTR:  ;
            MODE_LOAD, MODE_STORE: is_lookup = 1'b1;
            MODE_MODIFY: begin
                is_lookup = 1'b1;
                is_modify = 1'b1;
            end
            default: ;
        endcase
    end

    // Hold off new accesses while the back end clears, the op queue is full, or the second lookup of a modify waits
    assign o_full    = ~i_ready | r_pend | i_opq_full;
    assign accept    = i_push & ~o_full;
    assign o_op_push = (r_pend & ~i_opq_full) | (accept & is_lookup);
    assign o_op_data = r_pend ? r_pend_op : {r_access_cnt, ~is_modify, set_idx, tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_access_cnt <= '0;
            r_pend       <= 1'b0;
        end else if (accept) begin
            r_access_cnt <= r_access_cnt + STAMP_W'(1);
            r_pend       <= is_modify;
        end else if (r_pend && !i_opq_full) begin
            r_pend       <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_op <= {r_access_cnt, 1'b1, set_idx, tag};
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/sac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_back
// Carries out lookups against the tag store: row read, compare, fill or
// evict with FIFO replacement, and running totals.
// ----------------------------------------------------------------------------
module sac_back
    import sac_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [$clog2(MAX_WAYS+1)-1:0] i_ways,
    input  wire logic                  i_op_empty,
    input  wire logic [STAMP_W+1+((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)+ADDR_WIDTH-1:0] i_op_data,
    output logic                       o_op_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output t_result                    o_result,
    output logic                       o_ready
);

    localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS = 1 << MAX_SET_BITS;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW   = $clog2(MAX_WAYS + 1);

    // Tag store: one row per set, all ways side by side
    logic [MAX_WAYS-1:0]                 mem_valid [ROWS];
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] mem_tag   [ROWS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    mem_stamp [ROWS];

    t_back_state                         r_state;
    t_back_state                         n_state;
    logic [SIW-1:0]                      r_clr_idx;
    logic [CNT_W-1:0]                    r_hit_cnt;
    logic [CNT_W-1:0]                    r_miss_cnt;
    logic [CNT_W-1:0]                    r_evict_cnt;
    logic [CNT_W-1:0]                    n_hit_cnt;
    logic [CNT_W-1:0]                    n_miss_cnt;
    logic [CNT_W-1:0]                    n_evict_cnt;

    logic [MAX_WAYS-1:0]                 r_rd_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    r_rd_stamp;
    logic [SIW-1:0]                      r_op_set;
    logic [ADDR_WIDTH-1:0]               r_op_tag;
    logic [STAMP_W-1:0]                  r_op_stamp;
    logic                                r_op_last;
    logic [WW-1:0]                       r_old_way;
    logic [STAMP_W-1:0]                  r_old_stamp;
    logic [WW-1:0]                       r_scan_way;

    logic [SIW-1:0]                      rd_addr;
    logic                                rd_en;
    logic                                wr_en;
    logic [SIW-1:0]                      wr_addr;
    logic [MAX_WAYS-1:0]                 wr_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] wr_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    wr_stamp;

    logic [MAX_WAYS-1:0]                 hit_vec;
    logic [MAX_WAYS-1:0]                 blank_vec;
    logic [WW-1:0]                       blank_way;
    logic                                any_hit;
    logic                                any_blank;
    logic                                scan_lower;
    logic [WW-1:0]                       scan_pick;
    logic                                scan_last;
    logic                                start_scan;
    logic                                scan_step;
    logic                                finish;
    logic                                res_hit;
    logic                                res_evict;
    logic [WW-1:0]                       victim;

    assign rd_addr = i_op_data[ADDR_WIDTH +: SIW];
    assign o_ready = (r_state != ST_CLEAR);

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_valid[wr_addr] <= wr_valid;
            mem_tag[wr_addr]   <= wr_tag;
            mem_stamp[wr_addr] <= wr_stamp;
        end
        if (rd_en) begin
            r_rd_valid <= mem_valid[rd_addr];
            r_rd_tag   <= mem_tag[rd_addr];
            r_rd_stamp <= mem_stamp[rd_addr];
        end
    end

    // Compare the row against the lookup
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w]   = (w < int'(i_ways)) & r_rd_valid[w] & (r_rd_tag[w] == r_op_tag);
            blank_vec[w] = (w < int'(i_ways)) & ~r_rd_valid[w];
        end
    end

    assign any_hit   = |hit_vec;
    assign any_blank = |blank_vec;

    // Lowest-numbered free way
    always_comb begin
        blank_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (blank_vec[w]) begin
                blank_way = WW'(w);
            end
        end
    end

    // Oldest-stamp scan, one way per cycle; the lower way wins a tie
    assign scan_lower = (r_rd_stamp[r_scan_way] < r_old_stamp);
    assign scan_pick  = scan_lower ? r_scan_way : r_old_way;
    assign scan_last  = ((EW'(r_scan_way) + EW'(1)) == i_ways);

    always_comb begin
        n_state    = r_state;
        o_op_pop   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_op_set;
        finish     = 1'b0;
        res_hit    = 1'b0;
        res_evict  = 1'b0;
        victim     = blank_way;
        start_scan = 1'b0;
        scan_step  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                if (r_clr_idx == SIW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_op_empty && !i_res_full) begin
                    o_op_pop = 1'b1;
                    rd_en    = 1'b1;
                    n_state  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (any_hit) begin
                    finish  = 1'b1;
                    res_hit = 1'b1;
                    n_state = ST_IDLE;
                end else if (any_blank) begin
                    finish  = 1'b1;
                    wr_en   = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_ways == EW'(1)) begin
                    finish    = 1'b1;
                    wr_en     = 1'b1;
                    res_evict = 1'b1;
                    victim    = '0;
                    n_state   = ST_IDLE;
                end else begin
                    start_scan = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    finish    = 1'b1;
                    wr_en     = 1'b1;
                    res_evict = 1'b1;
                    victim    = scan_pick;
                    n_state   = ST_IDLE;
                end else begin
                    scan_step = 1'b1;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Row write-back: clear during the sweep, otherwise fill the victim way
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (r_state == ST_CLEAR) begin
                wr_valid[w] = 1'b0;
                wr_tag[w]   = '0;
                wr_stamp[w] = '0;
            end else if (w == int'(victim)) begin
                wr_valid[w] = 1'b1;
                wr_tag[w]   = r_op_tag;
                wr_stamp[w] = r_op_stamp;
            end else begin
                wr_valid[w] = r_rd_valid[w];
                wr_tag[w]   = r_rd_tag[w];
                wr_stamp[w] = r_rd_stamp[w];
            end
        end
    end

    assign n_hit_cnt   = r_hit_cnt + CNT_W'(res_hit);
    assign n_miss_cnt  = r_miss_cnt + CNT_W'(!res_hit);
    assign n_evict_cnt = r_evict_cnt + CNT_W'(res_evict);

    assign o_res_push               = finish;
    assign o_result.hit             = res_hit;
    assign o_result.miss            = ~res_hit;
    assign o_result.eviction        = res_evict;
    assign o_result.total_hits      = n_hit_cnt;
    assign o_result.total_misses    = n_miss_cnt;
    assign o_result.total_evictions = n_evict_cnt;
    assign o_result.last_result     = r_op_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SIW'(1);
            end
            if (finish) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_evict_cnt <= n_evict_cnt;
            end
        end
    end

    // Latch the lookup fields on pop, and keep the oldest stamp in step with the chosen way
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_op_stamp <= i_op_data[SIW + ADDR_WIDTH + 1 +: STAMP_W];
            r_op_last  <= i_op_data[SIW + ADDR_WIDTH];
            r_op_set   <= i_op_data[ADDR_WIDTH +: SIW];
            r_op_tag   <= i_op_data[ADDR_WIDTH-1:0];
        end
        if (start_scan) begin
            r_old_way   <= '0;
            r_old_stamp <= r_rd_stamp[0];
            r_scan_way  <= WW'(1);
        end else if (scan_step) begin
            r_old_way   <= scan_pick;
            r_old_stamp <= scan_lower ? r_rd_stamp[r_scan_way] : r_old_stamp;
            r_scan_way  <= r_scan_way + WW'(1);
        end
    end

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_res_push && !o_op_pop))
        else $error("lookup activity during the clearing sweep");

    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_pop |-> (!i_res_full && !i_op_empty))
        else $error("lookup started without room for its result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> ((r_hit_cnt + r_miss_cnt) ==
                        ($past(r_hit_cnt) + $past(r_miss_cnt) + CNT_W'(1))))
        else $error("hit and miss totals did not advance by one");

    a_evict_on_full_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_result.eviction) |-> (!any_blank && !any_hit))
        else $error("eviction with a free or matching way in the set");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (EW'(r_scan_way) < i_ways))
        else $error("replacement scan beyond the ways in use");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/set_assoc_cache_sim.sv
`default_nettype none
// Path: a load or store result goes through the op queue, the row read, then
//   compare and write-back, and the result queue; an eviction with more than
//   one way in use adds the oldest-stamp scan.
// Flow: the back end completes each lookup's row read-modify-write (plus the
//   scan on an eviction) before it pops another; a modify makes two lookups.
// Reset: synchronous; full stays high while the sweep clears the tag store rows.
// ----------------------------------------------------------------------------
// set_assoc_cache_sim
// Set-associative tag store with FIFO replacement and hit/miss/eviction totals.
// ----------------------------------------------------------------------------
module set_assoc_cache_sim
    import sac_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    input  wire t_access               i_access,
    output logic                       full,
    output t_result                    o_result,
    output logic                       empty,
    input  wire logic                  pop
);

    localparam int SIW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int EW        = $clog2(MAX_WAYS + 1);
    localparam int OP_W      = STAMP_W + 1 + SIW + ADDR_WIDTH;
    localparam int RES_W     = $bits(t_result);
    localparam int OPQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    logic              ready;
    logic              opq_full;
    logic              opq_empty;
    logic              op_push;
    logic              op_pop;
    logic [OP_W-1:0]   op_wr_data;
    logic [OP_W-1:0]   op_rd_data;
    logic [EW-1:0]     ways_eff;
    logic              res_full;
    logic              res_push;
    t_result           res_wr;
    logic [RES_W-1:0]  res_rd;

    sac_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_access    (i_access),
        .o_full      (full),
        .i_ready     (ready),
        .i_opq_full  (opq_full),
        .o_op_push   (op_push),
        .o_op_data   (op_wr_data),
        .o_ways      (ways_eff)
    );

    sac_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OPQ_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_wr_data),
        .o_full  (opq_full),
        .i_pop   (op_pop),
        .o_data  (op_rd_data),
        .o_empty (opq_empty)
    );

    sac_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ways     (ways_eff),
        .i_op_empty (opq_empty),
        .i_op_data  (op_rd_data),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (res_wr),
        .o_ready    (ready)
    );

    sac_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESQ_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wr),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rd),
        .o_empty (empty)
    );

    assign o_result = t_result'(res_rd);

endmodule
`default_nettype wire

>>> verif/cache_check_pkg.sv
// ----------------------------------------------------------------------------
// cache_check_pkg
// Tag store tracker for the cache simulator bench: mirrors the sets, ways,
// fill stamps and running totals, and checks each lookup result in order.
// ----------------------------------------------------------------------------
package cache_check_pkg;
    import sac_pkg::*;

    localparam int TRK_MAX_SET_BITS = 6;
    localparam int TRK_MAX_WAYS     = 8;
    localparam int TRK_LINES        = (1 << TRK_MAX_SET_BITS) * TRK_MAX_WAYS;
    localparam int TRK_ADDR_W       = 32;
    localparam int PRINT_CAP        = 200;

    class lookup_tracker;
        bit                    line_valid [TRK_LINES];
        bit [TRK_ADDR_W-1:0]   line_tag   [TRK_LINES];
        bit [STAMP_W-1:0]      fill_stamp [TRK_LINES];
        bit [SET_BITS_W-1:0]   set_bits_r;
        bit [WAYS_W-1:0]       ways_r;
        bit [BLOCK_BITS_W-1:0] block_bits_r;
        bit [STAMP_W-1:0]      access_count;
        bit [CNT_W-1:0]        hit_total;
        bit [CNT_W-1:0]        miss_total;
        bit [CNT_W-1:0]        evict_total;
        t_result               expected_lookups [$];
        int unsigned           mismatches;
        int unsigned           checked;

        function new();
            set_bits_r   = '0;
            ways_r       = 1;
            block_bits_r = '0;
            access_count = '0;
            hit_total    = '0;
            miss_total   = '0;
            evict_total  = '0;
            mismatches   = 0;
            checked      = 0;
            foreach (line_valid[i]) line_valid[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (t_cfg_reg'(idx))
                REG_SET_BITS:   set_bits_r   = data[SET_BITS_W-1:0];
                REG_WAYS:       ways_r       = data[WAYS_W-1:0];
                REG_BLOCK_BITS: block_bits_r = data[BLOCK_BITS_W-1:0];
                default: ;
            endcase
        endfunction

        function t_result predict_lookup(bit [TRK_ADDR_W-1:0] addr, bit last);
            int unsigned        s, e, shift, base, w, i, blank, oldest;
            bit [TRK_ADDR_W-1:0] set_idx, tag;
            bit                 have_blank, hit, evict;
            t_result            r;
            s = (set_bits_r > TRK_MAX_SET_BITS) ? TRK_MAX_SET_BITS : set_bits_r;
            e = (ways_r == 0) ? 1 : ((ways_r > TRK_MAX_WAYS) ? TRK_MAX_WAYS : ways_r);
            set_idx = (addr >> block_bits_r) & ((32'd1 << s) - 32'd1);
            shift = s + block_bits_r;
            tag = (shift >= TRK_ADDR_W) ? '0 : (addr >> shift);
            base = set_idx * TRK_MAX_WAYS;
            oldest = base;
            blank = 0;
            have_blank = 1'b0;
            hit = 1'b0;
            evict = 1'b0;
            for (w = 0; w < e; w++) begin
                i = base + w;
                if (line_valid[i] && line_tag[i] == tag) begin
                    hit = 1'b1;
                    break;
                end
                if (!line_valid[i] && !have_blank) begin
                    have_blank = 1'b1;
                    blank = i;
                end
                // strict compare: the lowest way wins a tie
                if (line_valid[i] && fill_stamp[i] < fill_stamp[oldest]) oldest = i;
            end
            if (hit) begin
                hit_total++;
            end else begin
                i = have_blank ? blank : oldest;
                evict = !have_blank;
                line_valid[i] = 1'b1;
                line_tag[i]   = tag;
                fill_stamp[i] = access_count;
                miss_total++;
                if (evict) evict_total++;
            end
            r.hit             = hit;
            r.miss            = !hit;
            r.eviction        = evict;
            r.total_hits      = hit_total;
            r.total_misses    = miss_total;
            r.total_evictions = evict_total;
            r.last_result     = last;
            return r;
        endfunction

        function void note_access(t_access a);
            case (a.mode) inside
                MODE_LOAD, MODE_STORE: begin
                    expected_lookups.push_back(predict_lookup(a.address, 1'b1));
                end
                MODE_MODIFY: begin
                    expected_lookups.push_back(predict_lookup(a.address, 1'b0));
                    expected_lookups.push_back(predict_lookup(a.address, 1'b1));
                end
                default: ;
            endcase
            access_count++;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] lookup %0d: %s", $time, checked, msg);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_lookups.size() == 0) begin
                report("result popped with no lookup outstanding");
            end else begin
                want = expected_lookups.pop_front();
                if (got.hit !== want.hit)
                    report($sformatf("hit %0b, want %0b", got.hit, want.hit));
                if (got.miss !== want.miss)
                    report($sformatf("miss %0b, want %0b", got.miss, want.miss));
                if (got.eviction !== want.eviction)
                    report($sformatf("eviction %0b, want %0b", got.eviction, want.eviction));
                if (got.total_hits !== want.total_hits)
                    report($sformatf("total_hits %0d, want %0d",
                                     got.total_hits, want.total_hits));
                if (got.total_misses !== want.total_misses)
                    report($sformatf("total_misses %0d, want %0d",
                                     got.total_misses, want.total_misses));
                if (got.total_evictions !== want.total_evictions)
                    report($sformatf("total_evictions %0d, want %0d",
                                     got.total_evictions, want.total_evictions));
                if (got.last_result !== want.last_result)
                    report($sformatf("last_result %0b, want %0b",
                                     got.last_result, want.last_result));
            end
            checked++;
        endtask
    endclass

endpackage

>>> verif/tb_set_assoc_cache_sim.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_sim
// Self-checking bench for the FIFO-replacement tag store: directed accesses
// over the geometry extremes, then random phases with reconfiguration, random
// push and pop stalls, and every lookup result checked against the tracker.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_sim;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;
    import cache_check_pkg::*;

    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   SETTLE       = 32;
    localparam int                   PHASES       = 7;
    localparam int                   PHASE_ITEMS  = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    t_access               i_access;
    logic                  full;
    t_result               o_result;
    logic                  empty;
    logic                  pop;

    lookup_tracker tracker;
    bit            tx_calm;
    bit            rx_calm;
    int unsigned   cycles;

    set_assoc_cache_sim u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .i_access    (i_access),
        .full        (full),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic tx_pause(int n);
        if (n > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_access(t_mode m, logic [IN_ADDR_W-1:0] a);
        @(negedge i_clk);
        push     <= 1'b1;
        i_access <= '{mode: m, address: a};
        do @(posedge i_clk); while (full);
        tracker.note_access(i_access);
    endtask

    // hold the sender until every lookup has come back, then let the block settle
    task automatic drain(int settle);
        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] wy,
                                logic [CFG_DATA_W-1:0] bb);
        drain(SETTLE);
        cfg_write(REG_SET_BITS, sb);
        cfg_write(REG_WAYS, wy);
        cfg_write(REG_BLOCK_BITS, bb);
    endtask

    // a few tags per set around a per-phase base, so hits and evictions are common
    function automatic logic [IN_ADDR_W-1:0] pick_address(logic [IN_ADDR_W-1:0] hi_base);
        int unsigned           s, e, bb;
        logic [IN_ADDR_W-1:0]  off_mask;
        if ($urandom_range(0, 3) == 0) return $urandom;
        s  = (tracker.set_bits_r > TRK_MAX_SET_BITS) ? TRK_MAX_SET_BITS : tracker.set_bits_r;
        e  = (tracker.ways_r == 0) ? 1 :
             ((tracker.ways_r > TRK_MAX_WAYS) ? TRK_MAX_WAYS : tracker.ways_r);
        bb = tracker.block_bits_r;
        off_mask = ~(32'hFFFF_FFFF << bb);
        return hi_base ^ (32'($urandom_range(0, e + 1)) << (s + bb))
                       ^ (32'($urandom_range(0, 3)) << bb)
                       ^ ($urandom & off_mask);
    endfunction

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) tracker.check_result(o_result);
        end
    end

    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                stall = pick_gap(rx_calm);
            end
        end
    end

    initial begin
        logic [IN_ADDR_W-1:0] hi_base;
        logic [CFG_DATA_W-1:0] bb;
        int k;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        push        = 1'b0;
        i_access    = '0;
        tx_calm     = 1'b1;
        rx_calm     = 1'b0;
        tracker     = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: one set, one way, byte blocks
        send_access(MODE_LOAD, 32'hFFFF_FFFF);
        send_access(MODE_STORE, 32'hFFFF_FFFF);
        send_access(MODE_MODIFY, 32'h0000_0000);

        // four sets of two ways, 16-byte blocks: fill, hit, FIFO victim, no refresh on hit
        set_geometry(5'd2, 5'd2, 5'd4);
        send_access(MODE_INSTR, 32'h0000_0040);
        send_access(MODE_LOAD, 32'h0000_0000);
        send_access(MODE_LOAD, 32'h0000_0008);
        send_access(MODE_STORE, 32'h0000_0040);
        send_access(MODE_MODIFY, 32'h0000_0080);
        send_access(MODE_LOAD, 32'h0000_0080);
        send_access(MODE_LOAD, 32'h0000_0000);
        send_access(MODE_STORE, 32'h0000_0044);
        send_access(MODE_MODIFY, 32'hFFFF_FFF0);

        // set_bits and ways saturate; offset wide enough that the tag is zero
        set_geometry(5'd7, 5'd0, 5'd26);
        send_access(MODE_LOAD, 32'h1234_5678);
        send_access(MODE_STORE, 32'hFFFF_FFFF);
        send_access(MODE_MODIFY, 32'hFC00_0000);

        drain(SETTLE);
        cfg_write(REG_UNMAPPED, 5'd31);
        set_geometry(5'd6, 5'd15, 5'd31);
        send_access(MODE_LOAD, 32'h8000_0000);
        send_access(MODE_LOAD, 32'h7FFF_FFFF);
        send_access(MODE_MODIFY, 32'h8000_0001);

        // full ways in one set, then one more to force the oldest out
        set_geometry(5'd6, 5'd8, 5'd0);
        for (k = 0; k <= TRK_MAX_WAYS; k++) send_access(MODE_STORE, 32'(k) << 6);

        for (int ph = 0; ph < PHASES; ph++) begin
            bb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 6));
            set_geometry(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), bb);
            tx_calm = (ph == 2);
            rx_calm = (ph == 4);
            hi_base = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 49) == 0) drain(0);
                tx_pause(pick_gap(tx_calm));
                send_access(t_mode'($urandom_range(0, 3)), pick_address(hi_base));
            end
        end

        drain(SETTLE);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
